// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/tnma_pkg.sv =====
`default_nettype none
package tnma_pkg;

  localparam int unsigned GRID_WIDTH  = 256;
  localparam int unsigned GRID_HEIGHT = 256;
  localparam int unsigned COL_W       = $clog2(GRID_WIDTH);
  localparam int unsigned ROW_W       = $clog2(GRID_HEIGHT);

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

  localparam logic RK_WALL   = 1'b0;
  localparam logic RK_LIQUID = 1'b1;

  localparam logic [7:0] WALL_N = 8'h01;
  localparam logic [7:0] WALL_E = 8'h02;
  localparam logic [7:0] WALL_S = 8'h04;
  localparam logic [7:0] WALL_W = 8'h08;
  localparam logic [7:0] LIQ_FULL = 8'hFF;

  typedef struct packed {
    logic [15:0] liquid_owner;
    logic [7:0]  liquid_kind;
    logic [15:0] wall_owner;
    logic [7:0]  wall_kind;
  } cell_t;

  // older line is two rows up, newer line one row up
  typedef struct packed {
    cell_t older;
    cell_t newer;
  } line_pair_t;

  typedef struct packed {
    logic        result_kind;
    logic        last_of_run;
    logic [3:0]  sprite_row;
    logic [3:0]  sprite_col;
    logic [7:0]  neighbor_mask;
    logic [15:0] owner_id;
    logic [7:0]  tile_kind;
    logic [7:0]  cell_y;
    logic [7:0]  cell_x;
  } result_t;

  typedef struct packed {
    logic    wall_vld;
    logic    liq_vld;
    result_t wall_res;
    result_t liq_res;
  } judge_t;

endpackage
`default_nettype wire

// ===== rtl/tnma_line_mem.sv =====
`default_nettype none
module tnma_line_mem
  import tnma_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [COL_W-1:0] rd_addr_i,
  output line_pair_t            rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [COL_W-1:0] wr_addr_i,
  input  wire line_pair_t       wr_data_i
);

  line_pair_t mem_q [GRID_WIDTH];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/tnma_window.sv =====
`default_nettype none
module tnma_window
  import tnma_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire cell_t            cell_i,
  input  wire line_pair_t       up_i,
  input  wire logic [COL_W-1:0] x_i,
  input  wire logic [ROW_W-1:0] y_i,
  output judge_t                judge_o,
  output line_pair_t            wb_o
);

  cell_t col0_q [3];
  cell_t col1_q [3];
  cell_t win [3][3];

  logic             judge;
  logic [COL_W-1:0] cx;
  logic [ROW_W-1:0] cy;
  logic [7:0]       wc;
  logic [7:0]       lc;
  logic             tl, t, tr, l, rr, bl, b, br;
  logic [7:0]       wmask;
  logic [7:0]       lmask;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[r][0] = col0_q[r];
      win[r][1] = col1_q[r];
    end
    win[0][2] = up_i.older;
    win[1][2] = up_i.newer;
    win[2][2] = cell_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        col0_q[r] <= '0;
        col1_q[r] <= '0;
      end
    end else if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        col0_q[r] <= col1_q[r];
        col1_q[r] <= win[r][2];
      end
    end
  end

  // line store shifts down by one row at this column
  assign wb_o.older = up_i.newer;
  assign wb_o.newer = cell_i;

  assign judge = (x_i >= COL_W'(2)) && (y_i >= ROW_W'(2));
  assign cx    = x_i - COL_W'(1);
  assign cy    = y_i - ROW_W'(1);
  assign wc    = win[1][1].wall_kind;
  assign lc    = win[1][1].liquid_kind;

  assign tl = win[0][0].wall_kind == wc;
  assign t  = win[0][1].wall_kind == wc;
  assign tr = win[0][2].wall_kind == wc;
  assign l  = win[1][0].wall_kind == wc;
  assign rr = win[1][2].wall_kind == wc;
  assign bl = win[2][0].wall_kind == wc;
  assign b  = win[2][1].wall_kind == wc;
  assign br = win[2][2].wall_kind == wc;

  // a side connects unless it is buried in a solid block
  always_comb begin
    wmask = '0;
    if (t && !(tl && tr && l && rr)) wmask = wmask | WALL_N;
    if (rr && !(t && tr && b && br)) wmask = wmask | WALL_E;
    if (b && !(l && rr && bl && br)) wmask = wmask | WALL_S;
    if (l && !(t && b && tl && bl))  wmask = wmask | WALL_W;
  end

  // clockwise from north
  assign lmask[0] = win[0][1].liquid_kind == lc;
  assign lmask[1] = win[0][2].liquid_kind == lc;
  assign lmask[2] = win[1][2].liquid_kind == lc;
  assign lmask[3] = win[2][2].liquid_kind == lc;
  assign lmask[4] = win[2][1].liquid_kind == lc;
  assign lmask[5] = win[2][0].liquid_kind == lc;
  assign lmask[6] = win[1][0].liquid_kind == lc;
  assign lmask[7] = win[0][0].liquid_kind == lc;

  always_comb begin
    judge_o.wall_vld = judge && (wc != 8'h00);
    judge_o.liq_vld  = judge && (lc != 8'h00) && (lmask != LIQ_FULL);

    judge_o.wall_res.result_kind   = RK_WALL;
    judge_o.wall_res.last_of_run   = !judge_o.liq_vld;
    judge_o.wall_res.sprite_row    = 4'h0;
    judge_o.wall_res.sprite_col    = 4'h0;
    judge_o.wall_res.neighbor_mask = wmask;
    judge_o.wall_res.owner_id      = win[1][1].wall_owner;
    judge_o.wall_res.tile_kind     = wc;
    judge_o.wall_res.cell_y        = 8'(cy);
    judge_o.wall_res.cell_x        = 8'(cx);

    judge_o.liq_res.result_kind   = RK_LIQUID;
    judge_o.liq_res.last_of_run   = 1'b1;
    judge_o.liq_res.sprite_row    = 4'hF - lmask[7:4];
    judge_o.liq_res.sprite_col    = lmask[3:0];
    judge_o.liq_res.neighbor_mask = lmask;
    judge_o.liq_res.owner_id      = win[1][1].liquid_owner;
    judge_o.liq_res.tile_kind     = lc;
    judge_o.liq_res.cell_y        = 8'(cy);
    judge_o.liq_res.cell_x        = 8'(cx);
  end

endmodule
`default_nettype wire

// ===== rtl/tnma_out_queue.sv =====
`default_nettype none
module tnma_out_queue
  import tnma_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_a_i,
  input  wire result_t            res_a_i,
  input  wire logic               push_b_i,
  input  wire result_t            res_b_i,
  input  wire logic               pop_i,
  output result_t                 head_o,
  output logic [Q_CNT_W-1:0]      cnt_o
);

  result_t              ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic [Q_PTR_W-1:0]   wr_b;
  logic [Q_CNT_W-1:0]   n_push;

  // second result lands behind the first when both come in one beat
  assign wr_b   = push_a_i ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
  assign n_push = Q_CNT_W'(push_a_i) + Q_CNT_W'(push_b_i);

  always_comb begin
    wr_ptr_d = wr_ptr_q + Q_PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + Q_PTR_W'(pop_i);
    cnt_d    = cnt_q + n_push - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      ent_q[wr_ptr_q] <= res_a_i;
    end
    if (push_b_i) begin
      ent_q[wr_b] <= res_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o = ent_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

endmodule
`default_nettype wire

// ===== rtl/tile_neighbor_mask_autotiler_top.sv =====
// timing: a cell is registered in s1, its results in the result queue, where a
// second result of the same cell waits behind the first; throughput: one cell per
// cycle while the queue has room for two results, one line store read and one
// write per cell; a cell with a wall and a liquid result needs two output beats
// (one per cycle while m_axis_tready is high); reset: position counters, window and
// result queue clear at once; the line store has no clearing pass; ready at release
`default_nettype none
`include "assert_macros.svh"
module tile_neighbor_mask_autotiler_top
  import tnma_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // wall_kind, wall_owner, liquid_kind, liquid_owner
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cell_x, cell_y, tile_kind, owner_id, neighbor_mask, sprite_col, sprite_row
  output logic [55:0]      m_axis_tdata,
  // result_kind
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             s1_vld_q, s1_vld_d;
  cell_t            s1_cell_q;
  logic [COL_W-1:0] s1_x_q;
  logic [ROW_W-1:0] s1_y_q;

  logic             acc;
  logic             s1_adv;
  logic             room;
  logic             push_a, push_b;
  logic             pop;
  line_pair_t       up_data;
  line_pair_t       wb_data;
  judge_t           judge;
  result_t          head;
  logic [Q_CNT_W-1:0] q_cnt;

  assign room          = q_cnt <= Q_CNT_W'(Q_DEPTH - 2);
  assign s1_adv        = s1_vld_q && room;
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (col_q == COL_W'(GRID_WIDTH - 1)) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(GRID_HEIGHT - 1)) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    if (acc) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end else begin
      s1_vld_d = s1_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
      s1_x_q   <= '0;
      s1_y_q   <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      s1_vld_q <= s1_vld_d;
      if (acc) begin
        s1_x_q <= col_q;
        s1_y_q <= row_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_cell_q <= cell_t'(s_axis_tdata);
    end
  end

  // read of a column is taken with its cell; the write lands as that cell leaves s1,
  // long before the same column comes round again
  tnma_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (col_q),
    .rd_data_o (up_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_x_q),
    .wr_data_i (wb_data)
  );

  tnma_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .cell_i  (s1_cell_q),
    .up_i    (up_data),
    .x_i     (s1_x_q),
    .y_i     (s1_y_q),
    .judge_o (judge),
    .wb_o    (wb_data)
  );

  assign push_a = s1_adv && judge.wall_vld;
  assign push_b = s1_adv && judge.liq_vld;
  assign pop    = m_axis_tvalid && m_axis_tready;

  tnma_out_queue u_out_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .res_a_i  (judge.wall_res),
    .push_b_i (push_b),
    .res_b_i  (judge.liq_res),
    .pop_i    (pop),
    .head_o   (head),
    .cnt_o    (q_cnt)
  );

  assign m_axis_tvalid = q_cnt != '0;
  assign m_axis_tdata  = {head.sprite_row, head.sprite_col, head.neighbor_mask,
                          head.owner_id, head.tile_kind, head.cell_y, head.cell_x};
  assign m_axis_tuser  = head.result_kind;
  assign m_axis_tlast  = head.last_of_run;

  `ASSERT_PROP(a_wall_in, push_a |-> s1_x_q >= COL_W'(2) && s1_y_q >= ROW_W'(2), "border wall")
  `ASSERT_PROP(a_liq_not_full, push_b |-> judge.liq_res.neighbor_mask != LIQ_FULL, "full liquid")
  `ASSERT_PROP(a_col_wrap, (acc && col_q == COL_W'(GRID_WIDTH - 1)) |=> col_q == '0, "col wrap")
  `ASSERT_NEVER(a_q_bound, q_cnt > Q_CNT_W'(Q_DEPTH), "result queue overflow")

endmodule
`default_nettype wire
